FILE: rtl/imu_tilt_spin_classifier_top_assert.svh
// assertion macros shared by the checker of the imu tilt and spin classifier
`ifndef IMU_TILT_SPIN_CLASSIFIER_TOP_ASSERT_SVH
`define IMU_TILT_SPIN_CLASSIFIER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ITSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define ITSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/itsc_pkg.sv
// shared types and constants of the imu tilt and spin classifier
package itsc_pkg;

  // stream widths
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;

  localparam logic [CFG_INDEX_W-1:0] REG_X_OFF    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_OFF    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_Z_OFF    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TILT_THR = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPIN_THR = 3'd4;

  localparam logic signed [15:0] X_OFF_RST    = 16'sd50;
  localparam logic signed [15:0] Y_OFF_RST    = -16'sd180;
  localparam logic signed [15:0] Z_OFF_RST    = -16'sd10450;
  localparam logic [17:0]        TILT_THR_RST = 18'd1000;
  localparam logic [15:0]        SPIN_THR_RST = 16'd3000;

  // result codes
  localparam logic [2:0] TILT_NONE  = 3'd0;
  localparam logic [2:0] TILT_BACK  = 3'd1;
  localparam logic [2:0] TILT_RIGHT = 3'd2;
  localparam logic [2:0] TILT_FRONT = 3'd3;
  localparam logic [2:0] TILT_LEFT  = 3'd4;

  localparam logic [1:0] SPIN_NONE  = 2'd0;
  localparam logic [1:0] SPIN_ANTI  = 2'd1;
  localparam logic [1:0] SPIN_CLOCK = 2'd2;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  // configuration register set
  typedef struct packed {
    logic signed [15:0] x_off;
    logic signed [15:0] y_off;
    logic signed [15:0] z_off;
    logic [17:0]        tilt_thr;
    logic [15:0]        spin_thr;
  } cfg_regs_t;

  // block sums handed from front to back
  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic signed [21:0] s;
  } sums_t;

  // rounded means
  typedef struct packed {
    logic signed [18:0] x;
    logic signed [18:0] y;
    logic signed [18:0] z;
    logic signed [16:0] s;
  } means_t;

endpackage

FILE: rtl/itsc_front.sv
// front part: offset correction and saturating block accumulation
module itsc_front #(
  parameter int SAMPLES = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [18:0]  accel_x,
  input  logic signed [18:0]  accel_y,
  input  logic signed [18:0]  accel_z,
  input  logic signed [16:0]  gyro_z,
  input  itsc_pkg::cfg_regs_t cfg,
  input  logic                q_full,
  output logic                push,
  output itsc_pkg::sums_t     push_sums
);

  localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);

  logic [CNT_W-1:0]   cnt_r;
  logic signed [23:0] sum_x_r, sum_y_r, sum_z_r;
  logic signed [21:0] sum_s_r;
  logic signed [23:0] sum_x_nxt, sum_y_nxt, sum_z_nxt;
  logic signed [21:0] sum_s_nxt;
  logic signed [19:0] cx, cy, cz;
  logic               is_last, accept;

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    if (v > 25'sd8388607) begin
      return 24'sh7fffff;
    end else if (v < -25'sd8388608) begin
      return 24'sh800000;
    end
    return 24'(v);
  endfunction

  function automatic logic signed [21:0] sat22(input logic signed [22:0] v);
    if (v > 23'sd2097151) begin
      return 22'sh1fffff;
    end else if (v < -23'sd2097152) begin
      return 22'sh200000;
    end
    return 22'(v);
  endfunction

  // corrected samples and saturated running sums
  always_comb begin
    cx = 20'(accel_x) + 20'(cfg.x_off);
    cy = 20'(accel_y) + 20'(cfg.y_off);
    cz = 20'(accel_z) + 20'(cfg.z_off);
    sum_x_nxt = sat24(25'(sum_x_r) + 25'(cx));
    sum_y_nxt = sat24(25'(sum_y_r) + 25'(cy));
    sum_z_nxt = sat24(25'(sum_z_r) + 25'(cz));
    sum_s_nxt = sat22(23'(sum_s_r) + 23'(gyro_z));
  end

  // handshake: the closing sample needs a free queue slot
  assign is_last  = (cnt_r == CNT_LAST);
  assign in_ready = !is_last || !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && is_last;

  assign push_sums.x = sum_x_nxt;
  assign push_sums.y = sum_y_nxt;
  assign push_sums.z = sum_z_nxt;
  assign push_sums.s = sum_s_nxt;

  // sample count and sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      sum_z_r <= '0;
      sum_s_r <= '0;
    end else if (accept) begin
      if (is_last) begin
        cnt_r   <= '0;
        sum_x_r <= '0;
        sum_y_r <= '0;
        sum_z_r <= '0;
        sum_s_r <= '0;
      end else begin
        cnt_r   <= cnt_r + CNT_W'(1);
        sum_x_r <= sum_x_nxt;
        sum_y_r <= sum_y_nxt;
        sum_z_r <= sum_z_nxt;
        sum_s_r <= sum_s_nxt;
      end
    end
  end

endmodule

FILE: rtl/itsc_queue.sv
// short queue of block sums between the front and back parts
module itsc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  itsc_pkg::sums_t push_data,
  output logic            full,
  input  logic            pop,
  output itsc_pkg::sums_t pop_data,
  output logic            empty
);

  localparam int PW = itsc_pkg::QUEUE_PTR_W;

  itsc_pkg::sums_t mem_r [itsc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     count_r;

  assign full     = (count_r == (PW+1)'(itsc_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + (PW+1)'(1);
        2'b01:   count_r <= count_r - (PW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: rtl/itsc_mean.sv
// back part, first half: sum / (10 * block length), rounded, then times ten
module itsc_mean #(
  parameter int SAMPLES = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  itsc_pkg::sums_t  in_sums,
  output logic             out_valid,
  output itsc_pkg::means_t out_means
);

  // reciprocal divide: q = floor(n / DIV) with n below 2**24
  localparam int DIV  = 10 * SAMPLES;
  localparam int BIAS = 5 * SAMPLES;
  localparam int K    = 25;
  localparam longint RECIP = (64'd1 << K) / DIV;
  localparam int MW   = $clog2(RECIP + 1);
  localparam int QW   = 21;
  localparam int PRW  = 24 + MW;
  localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

  logic v0_r, v1_r, v2_r, v3_r;
  logic signed [23:0] lane_sum [4];
  logic signed [18:0] lane_mean [4];

  assign lane_sum[0] = in_sums.x;
  assign lane_sum[1] = in_sums.y;
  assign lane_sum[2] = in_sums.z;
  assign lane_sum[3] = 24'(in_sums.s);

  // stage valids, whole back pipeline moves on adv
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    localparam int W = (i == 3) ? 17 : 19;
    localparam logic [24:0] LIM = 25'(2 ** (W - 1));

    logic [23:0]        n0_r, n1_r;
    logic               neg0_r, neg1_r, neg2_r;
    logic [PRW-1:0]     prod1_r;
    logic [QW-1:0]      q2_r;
    logic signed [18:0] mean3_r;
    logic [23:0]        mag, rem;
    logic [QW-1:0]      q_est, q_fix;
    logic [24:0]        m;
    logic signed [24:0] res;

    // magnitude plus half divisor
    assign mag = lane_sum[i][23] ? 24'(-lane_sum[i]) : 24'(lane_sum[i]);

    // quotient estimate and one-step correction
    always_comb begin
      q_est = QW'(prod1_r >> K);
      rem   = n1_r - 24'(q_est * DIV);
      q_fix = q_est + QW'(rem >= 24'(DIV));
    end

    // scale back by ten, restore sign, saturate to field width
    always_comb begin
      m = 25'({q2_r, 3'b000}) + 25'({q2_r, 1'b0});
      if (neg2_r) begin
        res = (m > LIM) ? -25'(LIM) : -25'(m);
      end else begin
        res = (m >= LIM) ? 25'(LIM - 25'd1) : 25'(m);
      end
    end

    // lane pipeline registers
    always_ff @(posedge clk) begin
      if (adv) begin
        n0_r    <= mag + 24'(BIAS);
        neg0_r  <= lane_sum[i][23];
        prod1_r <= PRW'(n0_r) * PRW'(RECIP_C);
        n1_r    <= n0_r;
        neg1_r  <= neg0_r;
        q2_r    <= q_fix;
        neg2_r  <= neg1_r;
        mean3_r <= 19'(res);
      end
    end

    assign lane_mean[i] = mean3_r;
  end

  assign out_valid   = v3_r;
  assign out_means.x = lane_mean[0];
  assign out_means.y = lane_mean[1];
  assign out_means.z = lane_mean[2];
  assign out_means.s = 17'(lane_mean[3]);

endmodule

FILE: rtl/itsc_class.sv
// back part, second half: tilt sector and spin classification, output register
module itsc_class (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  itsc_pkg::means_t in_means,
  input  logic [17:0]      tilt_thr,
  input  logic [15:0]      spin_thr,
  output logic             out_valid,
  output logic [2:0]       tilt_code,
  output logic [1:0]       spin_code,
  output itsc_pkg::means_t out_means
);

  logic v1_r, v2_r, v3_r;

  // stage 1: magnitudes, sum and difference, thresholds, spin
  logic [18:0]      ax, ay;
  logic [18:0]      ax1_r, d1_r;
  logic [19:0]      s1_r;
  logic             gt1_r, over1_r, xpos1_r, ypos1_r;
  logic [1:0]       spin1_r, spin2_r;
  itsc_pkg::means_t m1_r, m2_r;
  logic [1:0]       spin_nxt;
  logic signed [17:0] ms_ext, sthr_ext;

  // stage 2: squares
  logic [37:0] x2_2_r, d2_2_r;
  logic [39:0] s2_2_r;
  logic        gt2_r, over2_r, xpos2_r, ypos2_r;

  // stage 3: sector decision
  logic [38:0] two_x2;
  logic        near_x, near_y;
  logic [2:0]  tilt_nxt;

  assign ax = in_means.x[18] ? 19'(-in_means.x) : 19'(in_means.x);
  assign ay = in_means.y[18] ? 19'(-in_means.y) : 19'(in_means.y);

  // spin direction against the threshold
  always_comb begin
    ms_ext   = 18'(in_means.s);
    sthr_ext = signed'({2'b00, spin_thr});
    if (ms_ext > sthr_ext) begin
      spin_nxt = itsc_pkg::SPIN_ANTI;
    end else if (ms_ext < -sthr_ext) begin
      spin_nxt = itsc_pkg::SPIN_CLOCK;
    end else begin
      spin_nxt = itsc_pkg::SPIN_NONE;
    end
  end

  // tangent-ratio sector tests
  always_comb begin
    two_x2 = {x2_2_r, 1'b0};
    near_x = s2_2_r < 40'(two_x2);
    near_y = gt2_r && (39'(d2_2_r) > two_x2);
    if (!over2_r) begin
      tilt_nxt = itsc_pkg::TILT_NONE;
    end else if (near_y) begin
      tilt_nxt = ypos2_r ? itsc_pkg::TILT_BACK : itsc_pkg::TILT_FRONT;
    end else if (near_x) begin
      tilt_nxt = xpos2_r ? itsc_pkg::TILT_LEFT : itsc_pkg::TILT_RIGHT;
    end else begin
      tilt_nxt = itsc_pkg::TILT_NONE;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      ax1_r   <= ax;
      s1_r    <= 20'(ax) + 20'(ay);
      d1_r    <= ay - ax;
      gt1_r   <= ay > ax;
      over1_r <= (ax > 19'(tilt_thr)) || (ay > 19'(tilt_thr));
      xpos1_r <= !in_means.x[18] && (in_means.x != '0);
      ypos1_r <= !in_means.y[18] && (in_means.y != '0);
      spin1_r <= spin_nxt;
      m1_r    <= in_means;

      x2_2_r  <= 38'(ax1_r) * 38'(ax1_r);
      d2_2_r  <= 38'(d1_r) * 38'(d1_r);
      s2_2_r  <= 40'(s1_r) * 40'(s1_r);
      gt2_r   <= gt1_r;
      over2_r <= over1_r;
      xpos2_r <= xpos1_r;
      ypos2_r <= ypos1_r;
      spin2_r <= spin1_r;
      m2_r    <= m1_r;

      tilt_code <= tilt_nxt;
      spin_code <= spin2_r;
      out_means <= m2_r;
    end
  end

  assign out_valid = v3_r;

endmodule

FILE: rtl/imu_tilt_spin_classifier_top.sv
// top level of the imu tilt and spin classifier
// Takes one sample (accel x, y, z and gyro z) per clock and, every SAMPLES samples,
// returns one result with the rounded block means and the tilt and spin codes.
// Input rate is one sample per cycle while out_tready stays high; a result reaches
// the output register after its closing sample passes the queue entry, the
// reciprocal-multiply rounding stages and the sector classification stages. The back
// pipeline advances as a whole only when the output register is empty or taken,
// and a four-entry queue of block sums sits in front of it, so the input stalls
// only on a closing sample that finds the queue full. Configuration writes are
// always taken and must be made while the block is idle.
module imu_tilt_spin_classifier_top #(
  parameter int SAMPLES = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: accel_x[18:0], accel_y[37:19], accel_z[56:38], gyro_z[73:57], zero pad
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [itsc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: tilt_code[2:0], spin_code[4:3], mean_x[23:5], mean_y[42:24],
  // mean_z[61:43], mean_spin[78:62], zero pad
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [itsc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [itsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [itsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  itsc_pkg::cfg_regs_t cfg_r;
  itsc_pkg::sums_t     push_sums, pop_sums;
  itsc_pkg::means_t    mean_out, class_means;
  logic                push, q_full, q_empty, pop, adv, mean_valid;
  logic [2:0]          tilt_code;
  logic [1:0]          spin_code;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_off    <= itsc_pkg::X_OFF_RST;
      cfg_r.y_off    <= itsc_pkg::Y_OFF_RST;
      cfg_r.z_off    <= itsc_pkg::Z_OFF_RST;
      cfg_r.tilt_thr <= itsc_pkg::TILT_THR_RST;
      cfg_r.spin_thr <= itsc_pkg::SPIN_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        itsc_pkg::REG_X_OFF:    cfg_r.x_off    <= 16'(cfg_data);
        itsc_pkg::REG_Y_OFF:    cfg_r.y_off    <= 16'(cfg_data);
        itsc_pkg::REG_Z_OFF:    cfg_r.z_off    <= 16'(cfg_data);
        itsc_pkg::REG_TILT_THR: cfg_r.tilt_thr <= cfg_data;
        itsc_pkg::REG_SPIN_THR: cfg_r.spin_thr <= 16'(cfg_data);
        default:                cfg_r          <= cfg_r;
      endcase
    end
  end

  // front: accumulate blocks
  itsc_front #(
    .SAMPLES (SAMPLES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .accel_x   (in_tdata[18:0]),
    .accel_y   (in_tdata[37:19]),
    .accel_z   (in_tdata[56:38]),
    .gyro_z    (in_tdata[73:57]),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push      (push),
    .push_sums (push_sums)
  );

  // queue between front and back
  itsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_sums),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_sums),
    .empty     (q_empty)
  );

  // back pipeline moves when the output register is free or taken
  assign adv = !out_tvalid || out_tready;
  assign pop = adv && !q_empty;

  itsc_mean #(
    .SAMPLES (SAMPLES)
  ) u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (pop),
    .in_sums   (pop_sums),
    .out_valid (mean_valid),
    .out_means (mean_out)
  );

  itsc_class u_class (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (mean_valid),
    .in_means  (mean_out),
    .tilt_thr  (cfg_r.tilt_thr),
    .spin_thr  (cfg_r.spin_thr),
    .out_valid (out_tvalid),
    .tilt_code (tilt_code),
    .spin_code (spin_code),
    .out_means (class_means)
  );

  // result packing
  assign out_tdata = {1'b0, class_means.s, class_means.z, class_means.y, class_means.x,
                      spin_code, tilt_code};

endmodule

FILE: rtl/itsc_check.sv
// port-level checker of the imu tilt and spin classifier, bound to the top level
`include "imu_tilt_spin_classifier_top_assert.svh"

module itsc_check (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [itsc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             cfg_ready
);

  // a stalled result holds
  `ITSC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // tilt code stays within the five defined codes (none and four sectors)
  `ITSC_ASSERT_NOW(a_tilt_range, out_tvalid, out_tdata[2:0] <= itsc_pkg::TILT_LEFT, "tilt code out of range")

  // anticlockwise spin needs a positive mean rate
  `ITSC_ASSERT_NOW(a_spin_anti, out_tvalid && out_tdata[4:3] == itsc_pkg::SPIN_ANTI, !out_tdata[78] && out_tdata[78:62] != 17'd0, "anticlockwise spin with non-positive mean")

  // clockwise spin needs a negative mean rate, and no unused code appears
  `ITSC_ASSERT_NOW(a_spin_clock, out_tvalid && out_tdata[4:3] != itsc_pkg::SPIN_NONE && out_tdata[4:3] != itsc_pkg::SPIN_ANTI, out_tdata[4:3] == itsc_pkg::SPIN_CLOCK && out_tdata[78], "bad clockwise spin result")

  // configuration writes are never refused
  `ITSC_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready, "configuration port not ready")

endmodule

bind imu_tilt_spin_classifier_top itsc_check u_itsc_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);

FILE: tb/sv/imu_tilt_spin_classifier_top_tb.sv
// testbench of the imu tilt and spin classifier: sample blocks checked against a block-mean predictor
`timescale 1ns / 1ps

module imu_tilt_spin_classifier_top_tb;
  import itsc_pkg::*;

  localparam int BLOCK_LEN     = 10;
  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_PRINTS    = 40;
  localparam int HOLD_CYCLES   = 400;

  // field spans of the sensor samples
  localparam longint ACC_SPAN  = 160000;
  localparam longint GYRO_SPAN = 35000;
  localparam int     ACC_W     = 19;
  localparam int     GYRO_W    = 17;

  // register indexes that the block does not decode
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef enum int {SET_TYPICAL, SET_TOP, SET_BOTTOM, SET_WILD} setting_e;

  typedef struct {
    logic signed [18:0] ax;
    logic signed [18:0] ay;
    logic signed [18:0] az;
    logic signed [16:0] gz;
  } imu_sample_t;

  typedef struct {
    logic [2:0]         tilt;
    logic [1:0]         spin;
    logic signed [18:0] mx;
    logic signed [18:0] my;
    logic signed [18:0] mz;
    logic signed [16:0] ms;
  } block_summary_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // predictor copy of the registers and the running block sums
  logic signed [15:0] x_off_m;
  logic signed [15:0] y_off_m;
  logic signed [15:0] z_off_m;
  logic [17:0]        tilt_thr_m;
  logic [15:0]        spin_thr_m;
  int                 fill_count;
  longint             acc_x, acc_y, acc_z, acc_g;
  block_summary_t     summary_q[$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_left          = 0;
  int error_count        = 0;
  int cycle_count        = 0;

  imu_tilt_spin_classifier_top #(
    .SAMPLES(BLOCK_LEN)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("imu_tilt_spin_classifier_top: mismatch");
      $finish;
    end
  end

  // receiver: long hold-off when asked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic report_mismatch(string msg);
    if (error_count < MAX_PRINTS) $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count = error_count + 1;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // compare each taken result with the oldest awaited block summary
  always @(posedge clk) begin : check_results
    block_summary_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (summary_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing awaited, tdata %h", out_tdata));
      end else begin
        want = summary_q.pop_front();
        check_field("tilt_code", longint'(out_tdata[2:0]), longint'(want.tilt));
        check_field("spin_code", longint'(out_tdata[4:3]), longint'(want.spin));
        check_field("mean_x", longint'($signed(out_tdata[23:5])), longint'(want.mx));
        check_field("mean_y", longint'($signed(out_tdata[42:24])), longint'(want.my));
        check_field("mean_z", longint'($signed(out_tdata[61:43])), longint'(want.mz));
        check_field("mean_spin", longint'($signed(out_tdata[78:62])), longint'(want.ms));
      end
    end
  end

  function automatic longint clamp_signed(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // block mean rounded to the nearest ten, halves away from zero
  function automatic longint mean_to_ten(longint total, int w);
    longint mag, m;
    mag = (total < 0) ? -total : total;
    m = ((mag + BLOCK_LEN * 5) / (BLOCK_LEN * 10)) * 10;
    return clamp_signed((total < 0) ? -m : m, w);
  endfunction

  // sector test against tan 22.5 and tan 67.5 without division
  function automatic logic [2:0] tilt_sector(longint x, longint y);
    longint ax, ay, twice_x2;
    bit near_x, near_y;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    twice_x2 = 2 * ax * ax;
    near_x = (ax + ay) * (ax + ay) < twice_x2;
    near_y = (ay > ax) && ((ay - ax) * (ay - ax) > twice_x2);
    if (near_y) return (y > 0) ? TILT_BACK : TILT_FRONT;
    if (near_x) return (x > 0) ? TILT_LEFT : TILT_RIGHT;
    return TILT_NONE;
  endfunction

  task automatic clear_sums;
    fill_count = 0;
    acc_x = 0;
    acc_y = 0;
    acc_z = 0;
    acc_g = 0;
  endtask

  // accumulate one accepted sample, close the block on the last one
  task automatic fold_sample(imu_sample_t s);
    block_summary_t r;
    longint mx, my, ms, tthr, sthr;
    acc_x = clamp_signed(acc_x + longint'(s.ax) + longint'(x_off_m), 24);
    acc_y = clamp_signed(acc_y + longint'(s.ay) + longint'(y_off_m), 24);
    acc_z = clamp_signed(acc_z + longint'(s.az) + longint'(z_off_m), 24);
    acc_g = clamp_signed(acc_g + longint'(s.gz), 22);
    fill_count = fill_count + 1;
    if (fill_count == BLOCK_LEN) begin
      mx = mean_to_ten(acc_x, ACC_W);
      my = mean_to_ten(acc_y, ACC_W);
      ms = mean_to_ten(acc_g, GYRO_W);
      r.mx = 19'(mx);
      r.my = 19'(my);
      r.mz = 19'(mean_to_ten(acc_z, ACC_W));
      r.ms = 17'(ms);
      tthr = longint'(tilt_thr_m);
      sthr = longint'(spin_thr_m);
      if ((mx < 0 ? -mx : mx) > tthr || (my < 0 ? -my : my) > tthr)
        r.tilt = tilt_sector(mx, my);
      else
        r.tilt = TILT_NONE;
      if (ms > sthr)
        r.spin = SPIN_ANTI;
      else if (ms < -sthr)
        r.spin = SPIN_CLOCK;
      else
        r.spin = SPIN_NONE;
      summary_q.push_back(r);
      clear_sums();
    end
  endtask

  function automatic imu_sample_t make_sample(longint x, longint y, longint z, longint g);
    imu_sample_t s;
    s.ax = 19'(clamp_signed(x, ACC_W));
    s.ay = 19'(clamp_signed(y, ACC_W));
    s.az = 19'(clamp_signed(z, ACC_W));
    s.gz = 17'(clamp_signed(g, GYRO_W));
    return s;
  endfunction

  // one request on the sample stream, with random idle cycles ahead of it
  task automatic send_sample(imu_sample_t s);
    logic [IN_TDATA_W-1:0] word;
    int gap;
    word = '0;
    word[18:0]  = s.ax;
    word[37:19] = s.ay;
    word[56:38] = s.az;
    word[73:57] = s.gz;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    fold_sample(s);
  endtask

  // stop offering samples and wait out every awaited result plus the pipeline
  task automatic wait_drained;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (summary_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      REG_X_OFF:    x_off_m = data[15:0];
      REG_Y_OFF:    y_off_m = data[15:0];
      REG_Z_OFF:    z_off_m = data[15:0];
      REG_TILT_THR: tilt_thr_m = data[17:0];
      REG_SPIN_THR: spin_thr_m = data[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(setting_e which);
    wait_drained();
    case (which)
      SET_TYPICAL: begin
        write_reg(REG_X_OFF, 18'(int'($urandom_range(40000)) - 20000));
        write_reg(REG_Y_OFF, 18'(int'($urandom_range(40000)) - 20000));
        write_reg(REG_Z_OFF, 18'(int'($urandom_range(40000)) - 20000));
        write_reg(REG_TILT_THR, 18'(10 * $urandom_range(16000)));
        write_reg(REG_SPIN_THR, 18'(10 * $urandom_range(3500)));
      end
      SET_TOP: begin
        write_reg(REG_X_OFF, 18'(32767));
        write_reg(REG_Y_OFF, 18'(32767));
        write_reg(REG_Z_OFF, 18'(32767));
        write_reg(REG_TILT_THR, 18'(0));
        write_reg(REG_SPIN_THR, 18'(0));
      end
      SET_BOTTOM: begin
        write_reg(REG_X_OFF, 18'(-32768));
        write_reg(REG_Y_OFF, 18'(-32768));
        write_reg(REG_Z_OFF, 18'(-32768));
        write_reg(REG_TILT_THR, 18'h3ffff);
        write_reg(REG_SPIN_THR, 18'(65535));
      end
      default: begin
        write_reg(REG_X_OFF, 18'($urandom()));
        write_reg(REG_Y_OFF, 18'($urandom()));
        write_reg(REG_Z_OFF, 18'($urandom()));
        write_reg(REG_TILT_THR, 18'($urandom()));
        write_reg(REG_SPIN_THR, 18'($urandom()));
      end
    endcase
  endtask

  // axis target: anywhere, at the threshold or ten either side of it, or a mean ending in five
  function automatic longint pick_target(longint span, longint thr, longint off);
    longint sgn;
    sgn = ($urandom_range(1) == 0) ? -1 : 1;
    case ($urandom_range(3))
      0, 1:    return longint'($urandom_range(int'(2 * span))) - span;
      2:       return sgn * (thr + (longint'($urandom_range(2)) - 1) * 10) - off;
      default: return (longint'($urandom_range(600)) - 300) * 10 + 5 - off;
    endcase
  endfunction

  function automatic longint corner_value(int w);
    longint top;
    top = (longint'(1) << (w - 1)) - 1;
    case ($urandom_range(4))
      0:       return top;
      1:       return -top - 1;
      2:       return 0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  // a block around one base sample, noise in cancelling pairs keeps the sum exact unless a sample clamps
  task automatic send_block_of(imu_sample_t base, int amp);
    imu_sample_t s;
    longint n;
    int i;
    n = 0;
    for (i = 0; i < BLOCK_LEN; i++) begin
      if (i % 2 == 0) n = longint'($urandom_range(2 * amp)) - amp;
      else n = -n;
      s = make_sample(longint'(base.ax) + n, longint'(base.ay) - n,
                      longint'(base.az) + n, longint'(base.gz) - n);
      send_sample(s);
    end
  endtask

  task automatic send_random_block;
    imu_sample_t s;
    int pick, i;
    pick = $urandom_range(99);
    if (pick < 60) begin
      s = make_sample(pick_target(ACC_SPAN, longint'(tilt_thr_m), longint'(x_off_m)),
                      pick_target(ACC_SPAN, longint'(tilt_thr_m), longint'(y_off_m)),
                      pick_target(ACC_SPAN, 0, longint'(z_off_m)),
                      pick_target(GYRO_SPAN, longint'(spin_thr_m), 0));
      send_block_of(s, ($urandom_range(1) == 0) ? 0 : int'($urandom_range(60)));
    end else if (pick < 85) begin
      // full-width noise on every field
      for (i = 0; i < BLOCK_LEN; i++) begin
        s = make_sample(longint'($urandom_range(524287)) - 262144,
                        longint'($urandom_range(524287)) - 262144,
                        longint'($urandom_range(524287)) - 262144,
                        longint'($urandom_range(131071)) - 65536);
        send_sample(s);
      end
    end else begin
      for (i = 0; i < BLOCK_LEN; i++) begin
        s = make_sample(corner_value(ACC_W), corner_value(ACC_W),
                        corner_value(ACC_W), corner_value(GYRO_W));
        send_sample(s);
      end
    end
  endtask

  // reset registers: saturated means, opposite corners, offsets cancelled to zero
  task automatic test_reset_extremes;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_block_of(make_sample(262143, -262144, 262143, 65535), 0);
    send_block_of(make_sample(-262144, 0, -262144, -65536), 0);
    send_block_of(make_sample(-50, 180, 10450, 0), 0);
    wait_drained();
  endtask

  // writes to undecoded indexes leave the registers alone
  task automatic test_unused_index;
    write_reg(REG_SPARE_5, 18'($urandom()));
    write_reg(REG_SPARE_6, 18'($urandom()));
    write_reg(REG_SPARE_7, 18'($urandom()));
    send_random_block();
    send_random_block();
  endtask

  task automatic test_settings_and_idling;
    int phase, k, b;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 63; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 63; end
        default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
      endcase
      for (k = 0; k < 4; k++) begin
        apply_setting(setting_e'((phase + k) % 4));
        for (b = 0; b < 9; b++) send_random_block();
      end
    end
  endtask

  // receiver holds off while samples keep coming, so the block stalls its input
  task automatic test_backpressure;
    int b;
    apply_setting(SET_TYPICAL);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_left = HOLD_CYCLES;
    for (b = 0; b < 20; b++) send_random_block();
    wait_drained();
  endtask

  // sender goes quiet until every awaited result is out
  task automatic test_pause_between_blocks;
    int round;
    sender_idle_pct = 31;
    receiver_stall_pct = 31;
    for (round = 0; round < 2; round++) begin
      send_random_block();
      send_random_block();
      wait_drained();
    end
  endtask

  initial begin
    x_off_m    = X_OFF_RST;
    y_off_m    = Y_OFF_RST;
    z_off_m    = Z_OFF_RST;
    tilt_thr_m = TILT_THR_RST;
    spin_thr_m = SPIN_THR_RST;
    clear_sums();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_extremes();
    test_unused_index();
    test_settings_and_idling();
    test_backpressure();
    test_pause_between_blocks();
    wait_drained();
    if (error_count == 0) begin
      $display("imu_tilt_spin_classifier_top: match");
    end else begin
      $display("imu_tilt_spin_classifier_top: mismatch");
    end
    $finish;
  end

endmodule
